// ===== sv/mlnp_pkg.sv =====
// Shared codes and controller/datapath interface types for the mono legato note block.
`default_nettype none
package mlnp_pkg;

  // Request command codes
  localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [1:0] CMD_ALL_OFF  = 2'd2;
  localparam logic [1:0] CMD_RSVD     = 2'd3;

  // Voice mode codes
  localparam logic [1:0] MODE_POLY   = 2'd0;
  localparam logic [1:0] MODE_MONO   = 2'd1;
  localparam logic [1:0] MODE_LEGATO = 2'd2;

  // Voice action codes
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_FORWARD  = 3'd1;
  localparam logic [2:0] ACT_START    = 3'd2;
  localparam logic [2:0] ACT_GLIDE    = 3'd3;
  localparam logic [2:0] ACT_STOP     = 3'd4;
  localparam logic [2:0] ACT_STOP_ALL = 3'd5;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Controller to datapath commands
  typedef struct packed {
    logic load_req;
    logic set_vel;
    logic clear;
    logic scan_start;
    logic scan_step;
    logic shift;
    logic commit;
    logic push;
    logic tail_rd;
    logic out_load;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] req_cmd;
    logic       mode_poly;
    logic       scan_done;
    logic       wr_zero;
    logic       wr_full;
    logic       out_free;
  } ctl_sts_t;

endpackage
`default_nettype wire

// ===== sv/mlnp_datapath.sv =====
// Datapath: request registers, held-note memory, scan pointers and result register.
`default_nettype none
module mlnp_datapath #(
  parameter int MAX_HELD = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire  [mlnp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire                             cfg_valid,
  input  wire  [1:0]                      cfg_data,
  input  mlnp_pkg::ctl_cmd_t              cmd,
  output mlnp_pkg::ctl_sts_t              sts,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [mlnp_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mlnp_pkg::*;

  localparam int IW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int CW = $clog2(MAX_HELD + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_HELD);

  // request registers
  logic [1:0] req_cmd_r;
  logic [4:0] chan_r;
  logic [6:0] note_r;
  logic [6:0] vel_r;
  logic       tail_r;
  logic       snd_r;

  logic [1:0]    mode_r;
  logic [6:0]    last_vel_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] rd_ptr_r;
  logic [CW-1:0] wr_ptr_r;
  logic          pend_r;
  logic          pend_first_r;
  logic          already_r;

  logic          out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // held-note memory
  logic [6:0] mem [MAX_HELD];
  logic [6:0] rd_q;
  logic          we;
  logic          re;
  logic [IW-1:0] wa;
  logic [IW-1:0] ra;
  logic [6:0]    wd;

  logic rd_more;
  logic keep;
  logic [CW-1:0] tail_idx;

  assign rd_more  = rd_ptr_r < count_r;
  assign keep     = pend_r && (cmd.shift ? !pend_first_r : (rd_q != note_r));
  assign tail_idx = count_r - 1'b1;

  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = wr_ptr_r[IW-1:0];
    ra = rd_ptr_r[IW-1:0];
    wd = rd_q;
    if (cmd.scan_step) begin
      re = rd_more;
      we = keep;
    end
    if (cmd.push) begin
      we = 1'b1;
      wa = count_r[IW-1:0];
      wd = note_r;
    end
    if (cmd.tail_rd) begin
      re = 1'b1;
      ra = tail_idx[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      chan_r    <= in_tdata[6:2];
      note_r    <= in_tdata[13:7];
      vel_r     <= in_tdata[20:14];
      tail_r    <= in_tdata[21];
      snd_r     <= in_tdata[22];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_cmd_r    <= CMD_RSVD;
    end else if (cmd.load_req) begin
      req_cmd_r    <= in_tdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_POLY;
      last_vel_r   <= '0;
      count_r      <= '0;
      rd_ptr_r     <= '0;
      wr_ptr_r     <= '0;
      pend_r       <= 1'b0;
      pend_first_r <= 1'b0;
      already_r    <= 1'b0;
    end else begin
      if (cfg_valid) mode_r <= cfg_data;
      if (cmd.set_vel) last_vel_r <= vel_r;
      if (cmd.clear) count_r <= '0;
      if (cmd.scan_start) begin
        rd_ptr_r <= '0;
        wr_ptr_r <= '0;
        pend_r   <= 1'b0;
      end else if (cmd.scan_step) begin
        pend_r       <= rd_more;
        pend_first_r <= (rd_ptr_r == '0);
        if (rd_more) rd_ptr_r <= rd_ptr_r + 1'b1;
        if (keep)    wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (cmd.commit) begin
        count_r <= wr_ptr_r;
        if (!cmd.shift) already_r <= (wr_ptr_r != '0);
      end
      if (cmd.push) count_r <= count_r + 1'b1;
    end
  end

  // result composition from request, list state and tail read
  logic [2:0] act;
  logic [6:0] onote;
  logic [6:0] ovel;
  logic       otail;
  logic       legato;

  assign legato = mode_r[1];

  always_comb begin
    act   = ACT_NONE;
    onote = '0;
    ovel  = '0;
    otail = 1'b0;
    case (req_cmd_r)
      CMD_ALL_OFF: begin
        act   = ACT_STOP_ALL;
        otail = tail_r;
      end
      CMD_NOTE_ON: begin
        onote = note_r;
        if (mode_r == MODE_POLY) begin
          act  = ACT_FORWARD;
          ovel = vel_r;
        end else if (legato && already_r && snd_r) begin
          act = ACT_GLIDE;
        end else begin
          act  = ACT_START;
          ovel = vel_r;
        end
      end
      CMD_NOTE_OFF: begin
        if (mode_r == MODE_POLY || count_r == '0) begin
          act   = ACT_STOP;
          onote = note_r;
          ovel  = vel_r;
          otail = tail_r;
        end else begin
          onote = rd_q;
          if (legato && snd_r) begin
            act = ACT_GLIDE;
          end else begin
            act  = ACT_START;
            ovel = last_vel_r;
          end
        end
      end
      default: act = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= {1'b0, otail, ovel, onote, chan_r, act};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.req_cmd   = req_cmd_r;
  assign sts.mode_poly = (mode_r == MODE_POLY);
  assign sts.scan_done = !pend_r && !rd_more;
  assign sts.wr_zero   = (wr_ptr_r == '0);
  assign sts.wr_full   = (wr_ptr_r == MAX_C);
  assign sts.out_free  = !out_valid_r || out_tready;

  // list never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C)
    else $error("held count above depth");

  // compaction never writes ahead of the read side
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> wr_ptr_r <= rd_ptr_r)
    else $error("scan write pointer passed read pointer");

  // appending needs a free slot
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> count_r < MAX_C)
    else $error("push into full list");

  // a new result never overwrites one still waiting
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

endmodule
`default_nettype wire

// ===== sv/mlnp_ctrl.sv =====
// Controller: sequences accept, list scans, append, tail read and result load.
`default_nettype none
module mlnp_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  input  mlnp_pkg::ctl_sts_t sts,
  output mlnp_pkg::ctl_cmd_t cmd
);
  import mlnp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_PUSH   = 3'd4;
  localparam logic [2:0] ST_TRD    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.req_cmd == CMD_ALL_OFF) begin
          cmd.clear = 1'b1;
          state_nxt = ST_OUT;
        end else if (sts.req_cmd == CMD_RSVD || sts.mode_poly) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.set_vel    = (sts.req_cmd == CMD_NOTE_ON);
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          cmd.commit = 1'b1;
          if (sts.req_cmd == CMD_NOTE_ON) begin
            if (sts.wr_full) begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SHIFT;
            end else begin
              state_nxt = ST_PUSH;
            end
          end else begin
            state_nxt = sts.wr_zero ? ST_OUT : ST_TRD;
          end
        end
      end
      ST_SHIFT: begin
        cmd.scan_step = 1'b1;
        cmd.shift     = 1'b1;
        if (sts.scan_done) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_TRD: begin
        cmd.tail_rd = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule
`default_nettype wire

// ===== sv/mono_legato_note_priority.sv =====
// Top level of the last-note-priority mono/legato voice controller.
`default_nettype none
// Turns note-on, note-off and all-notes-off requests into one voice action
// each. voice_mode (cfg port) picks poly forwarding, mono retrigger or legato
// glide; write it only while idle. In mono/legato the block keeps an ordered,
// duplicate-free list of up to MAX_HELD held notes in a small memory with one
// read and one write port, and rewrites it by compaction, one entry per cycle.
// Per request: all-notes-off, unused commands and poly events go from decode
// straight to the result register. In mono/legato the list is scanned first;
// a note-off then reads the new tail to fall back to the newest held note, or
// stops when the list is left empty; a note-on appends its note, and on a
// full list a second shift pass first drops the oldest note. The next request
// is accepted once the previous one is in the result register, at the edge at
// which that result can first be taken, so a stalled output holds nothing up
// until a second result is ready. No clearing pass after reset: only entries
// below the fill count are ever read.
module mono_legato_note_priority #(
  parameter int MAX_HELD = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  // request channel
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // [1:0] cmd, [6:2] channel, [13:7] note, [20:14] velocity,
  // [21] tail_off, [22] voice_sounding, [23] zero
  input  wire  [mlnp_pkg::IN_DATA_W-1:0]  in_tdata,
  // result channel
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // [2:0] action, [7:3] out_channel, [14:8] out_note,
  // [21:15] out_velocity, [22] out_tail_off, [23] zero
  output logic [mlnp_pkg::OUT_DATA_W-1:0] out_tdata,
  // voice_mode register write
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [1:0]                      cfg_data
);
  import mlnp_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // register write always taken; the user must issue it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;

  mlnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlnp_datapath #(
    .MAX_HELD (MAX_HELD)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ===== tb/mono_legato_note_priority_test.sv =====
// Self-checking bench for the mono/legato note priority block, with its own held-note tracker.
`default_nettype none
module mono_legato_note_priority_test;
  import mlnp_pkg::*;

  // Request fields, lowest bits last in the declaration so cmd lands at bit 0.
  typedef struct packed {
    logic       sounding;
    logic       tail;
    logic [6:0] vel;
    logic [6:0] note;
    logic [4:0] chan;
    logic [1:0] cmd;
  } note_request_t;

  // Voice action fields, action at bit 0.
  typedef struct packed {
    logic       tail;
    logic [6:0] vel;
    logic [6:0] note;
    logic [4:0] chan;
    logic [2:0] action;
  } voice_action_t;

  // Tracks held notes and last velocity, queues the voice action each request should give.
  class held_note_tracker;
    localparam int MAX_HELD = 16;

    logic [6:0]    held_notes[$];
    logic [6:0]    last_vel;
    logic [1:0]    mode;
    voice_action_t expected_actions[$];
    int            fail_count;
    int            requests_seen;
    int            actions_checked;
    int            overflow_drops;
    int            glides;

    function new();
      mode = MODE_POLY;
      last_vel = '0;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
    endfunction

    function int pending();
      return expected_actions.size();
    endfunction

    function void drop_held(logic [6:0] n);
      logic [6:0] kept[$];
      foreach (held_notes[i])
        if (held_notes[i] != n) kept.insert(kept.size(), held_notes[i]);
      held_notes = kept;
    endfunction

    function void accept_request(note_request_t r);
      voice_action_t a;
      bit            legato_on;
      bit            others_held;
      a = '0;
      a.chan = r.chan;
      a.action = ACT_NONE;
      // unused mode code behaves as legato
      legato_on = (mode >= MODE_LEGATO);
      requests_seen++;
      case (r.cmd)
        CMD_ALL_OFF: begin
          held_notes.delete();
          a.action = ACT_STOP_ALL;
          a.tail = r.tail;
        end
        CMD_NOTE_ON: begin
          if (mode == MODE_POLY) begin
            a.action = ACT_FORWARD;
            a.note = r.note;
            a.vel = r.vel;
          end else begin
            last_vel = r.vel;
            drop_held(r.note);
            others_held = (held_notes.size() > 0);
            if (held_notes.size() >= MAX_HELD) begin
              void'(held_notes.pop_front());
              overflow_drops++;
            end
            held_notes.insert(held_notes.size(), r.note);
            a.note = r.note;
            if (legato_on && others_held && r.sounding) begin
              a.action = ACT_GLIDE;
            end else begin
              a.action = ACT_START;
              a.vel = r.vel;
            end
          end
        end
        CMD_NOTE_OFF: begin
          if (mode != MODE_POLY) drop_held(r.note);
          if (mode == MODE_POLY || held_notes.size() == 0) begin
            a.action = ACT_STOP;
            a.note = r.note;
            a.vel = r.vel;
            a.tail = r.tail;
          end else begin
            // fall back to newest held note
            a.note = held_notes[$];
            if (legato_on && r.sounding) begin
              a.action = ACT_GLIDE;
            end else begin
              a.action = ACT_START;
              a.vel = last_vel;
            end
          end
        end
        default: ;
      endcase
      if (a.action == ACT_GLIDE) glides++;
      expected_actions.insert(expected_actions.size(), a);
    endfunction

    // one line per mismatch, each one counted
    task report(string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_action(logic [23:0] data);
      voice_action_t got;
      voice_action_t want;
      got = voice_action_t'(data[22:0]);
      if (expected_actions.size() == 0) begin
        report($sformatf("unexpected result, tdata %h", data));
        return;
      end
      want = expected_actions.pop_front();
      actions_checked++;
      if (got.action !== want.action)
        report($sformatf("action got %0d want %0d", got.action, want.action));
      if (got.chan !== want.chan)
        report($sformatf("channel got %0d want %0d", got.chan, want.chan));
      if (got.note !== want.note)
        report($sformatf("note got %0d want %0d", got.note, want.note));
      if (got.vel !== want.vel)
        report($sformatf("velocity got %0d want %0d", got.vel, want.vel));
      if (got.tail !== want.tail)
        report($sformatf("tail_off got %0b want %0b", got.tail, want.tail));
    endtask
  endclass

  // fourth mode code, not named by the package; the block treats it as legato
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         PHASE_ITEMS = 235;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [1:0] cmd, [6:2] channel, [13:7] note, [20:14] velocity,
  // [21] tail_off, [22] voice_sounding, [23] zero
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // [2:0] action, [7:3] out_channel, [14:8] out_note,
  // [21:15] out_velocity, [22] out_tail_off, [23] zero
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;

  held_note_tracker tracker = new();

  // idling controls; the rx ones are shared with the result sink
  int rx_max_stall = 6;
  int rx_long_hold = 0;
  int tx_max_gap   = 6;

  mono_legato_note_priority u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Build a request from its fields.
  function automatic note_request_t make_req(logic [1:0] cmd, logic [4:0] chan,
                                             logic [6:0] note, logic [6:0] vel,
                                             logic tail, logic sounding);
    note_request_t r;
    r.cmd = cmd;
    r.chan = chan;
    r.note = note;
    r.vel = vel;
    r.tail = tail;
    r.sounding = sounding;
    return r;
  endfunction

  // Random request. Notes mostly sit in a 24-note window so note-offs hit held
  // notes and note-on bursts overflow the list; on_bias sets the share of note-ons.
  function automatic note_request_t random_req(int on_bias, logic [6:0] base);
    note_request_t r;
    int            pick;
    pick = $urandom_range(0, 99);
    if (pick < on_bias)  r.cmd = CMD_NOTE_ON;
    else if (pick < 98)  r.cmd = CMD_NOTE_OFF;
    else if (pick < 99)  r.cmd = CMD_ALL_OFF;
    else                 r.cmd = CMD_RSVD;
    r.chan = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
    r.note = ($urandom_range(0, 9) == 0) ? 7'($urandom) : base + 7'($urandom_range(0, 23));
    r.vel = 7'($urandom);
    r.tail = 1'($urandom);
    r.sounding = ($urandom_range(0, 3) != 0);
    return r;
  endfunction

  // Offer one request after gap idle cycles; called and returns at a falling edge.
  // With no gap, tvalid simply stays high into the next request.
  task automatic send(input note_request_t r, input int gap);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {1'b0, r};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    tracker.accept_request(r);
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding action.
  task automatic settle();
    in_tvalid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // voice_mode write; only ever issued while the block is idle
  task automatic write_mode(input logic [1:0] m);
    cfg_valid = 1'b1;
    cfg_data = m;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    tracker.set_mode(m);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result sink: random stall per result, plus a long hold-off on request
  // from the stimulus side, counted here in cycles.
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_long_hold > 0) begin
        out_tready = 1'b0;
        repeat (rx_long_hold) @(negedge clk);
        rx_long_hold = 0;
      end
      stall = $urandom_range(0, rx_max_stall);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      tracker.check_action(out_tdata);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic [1:0] phase_modes[6];
    int         on_bias;
    logic [6:0] base;

    phase_modes = '{MODE_MONO, MODE_LEGATO, MODE_POLY, MODE_UNUSED, MODE_LEGATO, MODE_MONO};
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Poly after reset: forward, poly note-off as stop, unused command, all off.
    send(make_req(CMD_NOTE_ON, 5'd1, 7'd0, 7'd0, 1'b0, 1'b0), 0);
    send(make_req(CMD_NOTE_OFF, 5'd16, 7'd127, 7'd127, 1'b1, 1'b1), 0);
    send(make_req(CMD_RSVD, 5'd31, 7'd127, 7'd127, 1'b1, 1'b1), 0);
    send(make_req(CMD_ALL_OFF, 5'd0, 7'd0, 7'd0, 1'b1, 1'b0), 0);
    settle();

    // Unused mode code acts as legato: glide, duplicate note-on, fall-back,
    // note-off of a note not held, then stop on an empty list.
    write_mode(MODE_UNUSED);
    send(make_req(CMD_NOTE_ON, 5'd2, 7'd10, 7'd100, 1'b0, 1'b1), 0);
    send(make_req(CMD_NOTE_ON, 5'd2, 7'd20, 7'd80, 1'b0, 1'b1), 0);
    send(make_req(CMD_NOTE_ON, 5'd2, 7'd10, 7'd70, 1'b0, 1'b1), 0);
    send(make_req(CMD_NOTE_OFF, 5'd2, 7'd10, 7'd5, 1'b0, 1'b1), 0);
    send(make_req(CMD_NOTE_OFF, 5'd2, 7'd99, 7'd6, 1'b1, 1'b0), 0);
    send(make_req(CMD_NOTE_OFF, 5'd2, 7'd20, 7'd7, 1'b1, 1'b1), 0);
    settle();

    // Mono: seventeen note-ons overflow the list, the oldest is gone.
    write_mode(MODE_MONO);
    for (int k = 0; k < 17; k++)
      send(make_req(CMD_NOTE_ON, 5'd9, 7'(110 + k), 7'(k * 7), 1'b0, 1'b1), 0);
    send(make_req(CMD_NOTE_OFF, 5'd9, 7'd110, 7'd1, 1'b1, 1'b0), 0);
    send(make_req(CMD_ALL_OFF, 5'd9, 7'd0, 7'd0, 1'b0, 1'b0), 0);
    settle();

    // Random phases, one per mode setting; phase 4 runs with no idling at all.
    for (int p = 0; p < 6; p++) begin
      settle();
      write_mode(phase_modes[p]);
      tx_max_gap = (p == 4) ? 0 : 6;
      rx_max_stall = (p == 1 || p == 4) ? 0 : 6;
      on_bias = 60;
      base = '0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // new phrase every 40 requests: note window and note-on density change
        if (i % 40 == 0) begin
          case ($urandom_range(0, 2))
            0:       on_bias = 92;
            1:       on_bias = 60;
            default: on_bias = 30;
          endcase
          base = 7'($urandom_range(0, 104));
        end
        // sink holds off for a long stretch while requests keep coming
        if (p == 1 && i == 60) rx_long_hold = 300;
        // sender pauses until everything outstanding has come back
        if (p == 2 && i == 100) settle();
        send(random_req(on_bias, base), $urandom_range(0, tx_max_gap));
      end
    end

    settle();
    repeat (40) @(negedge clk);
    $display("Covered %0d requests over poly, mono, legato and the unused mode code;",
             tracker.requests_seen);
    $display("%0d actions checked, %0d glides, %0d held-list overflows.",
             tracker.actions_checked, tracker.glides, tracker.overflow_drops);
    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("** mono_legato_note_priority: PASSED **");
    end else begin
      $display("** mono_legato_note_priority: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #5000000;
    $display("Timed out with %0d actions outstanding", tracker.pending());
    $display("** mono_legato_note_priority: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/mlnp_pkg.sv
sv/mlnp_datapath.sv
sv/mlnp_ctrl.sv
sv/mono_legato_note_priority.sv
tb/mono_legato_note_priority_test.sv
